@@ sv/iost_pkg.sv @@
package iost_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int ACTION_W = 2;

    localparam int IN_BITS  = ACTION_W + VALUE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 + COUNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TEST   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [OCC_W-1:0]          t_occ;

    // per-request strobes broadcast along the row
    typedef struct packed {
        logic add_en;   // append request value at the tail cell
        logic rem_en;   // remove request: cells at or above the match shift down
    } t_cell_ctrl;

endpackage

@@ sv/iost_cell.sv @@
module iost_cell (
    input  logic                i_clk,
    input  iost_pkg::t_cell_ctrl i_ctrl,
    input  iost_pkg::t_value    i_value,
    input  logic                i_valid,
    input  logic                i_tail,
    input  logic                i_found,
    input  iost_pkg::t_value    i_next_value,
    output logic                o_found,
    output iost_pkg::t_value    o_value
);

    iost_pkg::t_value r_value;
    iost_pkg::t_value n_value;
    logic             w_match;

    assign w_match = i_valid && (r_value == i_value);
    assign o_found = i_found || w_match;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.rem_en && o_found) begin
            n_value = i_next_value;
        end else if (i_ctrl.add_en && i_tail) begin
            n_value = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ sv/insertion_ordered_set_table.sv @@
// Ordered set of up to iost_pkg::CAPACITY distinct signed 32-bit values, kept oldest first
// and packed from slot 0. Each input word carries an action (add, remove, test, clear)
// and a value; each gives one output word with hit, full_reject and the count after the
// request. The table is a row of cells: every cell compares its value with the request
// at once, a found flag ripples up the row, and on remove every cell at or above the
// match takes its upper neighbour's value. A request is handled in the clock cycle that
// takes it, and the cycle is set by the 32-bit compare plus the found ripple through all
// cells. Its result is valid in the output register in the next cycle. A new word is taken
// only while that register is empty or its word leaves in the same cycle, so one request
// per cycle while results are drained without stalls.
module insertion_ordered_set_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [iost_pkg::IN_W-1:0]  i_s_axis_tdata,  // action[1:0], value[33:2]
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [iost_pkg::OUT_W-1:0] o_m_axis_tdata   // hit, full_reject, count[6:2]
);

    localparam int CAP = iost_pkg::CAPACITY;

    logic [iost_pkg::ACTION_W-1:0] w_action;
    iost_pkg::t_value              w_value;
    logic                          w_accept;
    iost_pkg::t_cell_ctrl          w_ctrl;
    logic [CAP:0]                  w_found;
    iost_pkg::t_value              w_cell_val [CAP];
    logic                          w_found_all;
    logic                          w_full;

    iost_pkg::t_occ                r_occ;
    iost_pkg::t_occ                n_occ;
    logic                          r_out_valid;
    logic [iost_pkg::OUT_W-1:0]    r_out_data;
    logic                          n_hit;
    logic                          n_full_reject;

    assign w_action    = i_s_axis_tdata[iost_pkg::ACTION_W-1:0];
    assign w_value     = i_s_axis_tdata[iost_pkg::IN_BITS-1:iost_pkg::ACTION_W];
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_found_all = w_found[CAP];
    assign w_full      = (r_occ == iost_pkg::OCC_W'(CAP));
    assign w_found[0]  = 1'b0;

    assign w_ctrl.add_en = w_accept && (w_action == iost_pkg::ACT_ADD)
                           && !w_found_all && !w_full;
    assign w_ctrl.rem_en = w_accept && (w_action == iost_pkg::ACT_REMOVE);

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        iost_pkg::t_value w_next;
        if (g == CAP - 1) begin : g_top
            assign w_next = w_cell_val[g];
        end else begin : g_mid
            assign w_next = w_cell_val[g+1];
        end

        iost_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_value      (w_value),
            .i_valid      (iost_pkg::OCC_W'(g) < r_occ),
            .i_tail       (iost_pkg::OCC_W'(g) == r_occ),
            .i_found      (w_found[g]),
            .i_next_value (w_next),
            .o_found      (w_found[g+1]),
            .o_value      (w_cell_val[g])
        );
    end

    always_comb begin
        n_occ         = r_occ;
        n_hit         = 1'b0;
        n_full_reject = 1'b0;
        unique case (w_action)
            iost_pkg::ACT_ADD: begin
                if (!w_found_all) begin
                    if (w_full) begin
                        n_full_reject = 1'b1;
                    end else begin
                        n_occ = r_occ + 1'b1;
                        n_hit = 1'b1;
                    end
                end
            end
            iost_pkg::ACT_REMOVE: begin
                if (w_found_all) begin
                    n_occ = r_occ - 1'b1;
                    n_hit = 1'b1;
                end
            end
            iost_pkg::ACT_TEST: begin
                n_hit = w_found_all;
            end
            iost_pkg::ACT_CLEAR: begin
                n_occ = '0;
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= iost_pkg::OUT_W'({iost_pkg::COUNT_W'(n_occ), n_full_reject, n_hit});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
